>>> rtl/sptb_pkg.sv
// Shared constants for the Sv39 page table builder.
// No dependencies; imported by sptb_alu and the top-level core.
package sptb_pkg;

  localparam int unsigned VpnW            = 27;
  localparam int unsigned FrameW          = 44;
  localparam int unsigned CountW          = 20;
  localparam int unsigned PermW           = 8;
  localparam int unsigned TablesUsedW     = 7;
  localparam int unsigned IdxW            = 9;
  localparam int unsigned EntriesPerTable = 512;
  localparam int unsigned EntryW          = 64;
  localparam int unsigned PteShift        = 10;
  localparam int unsigned MaxTablesDef    = 64;

endpackage

>>> rtl/sptb_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; holds the page table entries of the builder.
module sptb_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> rtl/sptb_alu.sv
// Shared frame-width adder/subtractor of the page table builder.
// Depends on sptb_pkg for the frame width.
module sptb_alu (
  input  logic [sptb_pkg::FrameW-1:0] a_i,
  input  logic [sptb_pkg::FrameW-1:0] b_i,
  input  logic                        sub_i,
  output logic [sptb_pkg::FrameW-1:0] sum_o
);
  import sptb_pkg::*;

  logic [FrameW-1:0] b_eff;

  // two's complement subtract: invert b and carry in one
  assign b_eff = sub_i ? ~b_i : b_i;
  assign sum_o = a_i + b_eff + FrameW'(sub_i);

endmodule

>>> rtl/sv39_page_table_builder_core.sv
// Sv39 page table builder, top level.
// Depends on sptb_pkg, sptb_ram (table store) and sptb_alu (shared adder).
//
// Usage:
//   The config channel (cfg_valid_i/cfg_ready_o) writes table_base_frame, the
//   frame number of the root table; it is always ready. Write it only while
//   the block is idle. The input channel takes one mapping request per
//   transaction: start virtual page, start physical page, page count and
//   leaf permission bits. The output channel returns one transaction per
//   request: status (1 = table pool ran out), leaf entries written, and
//   tables allocated so far including the root.
// Sequencing:
//   After reset the block sweeps the table store to zero, all MAX_TABLES * 512
//   entries (32768 at the default), with in_ready_o low. A request then maps
//   its pages one at a time and takes no new request until it is finished; a
//   page may need a new level-1 table and a new leaf table. The single-port
//   table store serializes the work: every table read, pointer write and
//   leaf write uses it once, and the shared 44-bit adder serves the pointer
//   check, the frame computation and the physical page increment in turn.
// Stalls:
//   The result sits in an output register. The block accepts the next
//   request while it waits, and holds the following result until the
//   receiver takes the earlier one.
module sv39_page_table_builder_core #(
  parameter int unsigned MAX_TABLES = sptb_pkg::MaxTablesDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sptb_pkg::FrameW-1:0]      cfg_table_base_frame_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [sptb_pkg::VpnW-1:0]        virt_page_i,
  input  logic [sptb_pkg::FrameW-1:0]      phys_page_i,
  input  logic [sptb_pkg::CountW-1:0]      page_count_i,
  input  logic [sptb_pkg::PermW-1:0]       permission_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             status_o,
  output logic [sptb_pkg::CountW-1:0]      pages_mapped_o,
  output logic [sptb_pkg::TablesUsedW-1:0] tables_used_o
);
  import sptb_pkg::*;

  localparam int unsigned Depth   = MAX_TABLES * EntriesPerTable;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned TblW    = $clog2(MAX_TABLES);
  localparam int unsigned NfW     = $clog2(MAX_TABLES + 1);
  localparam int unsigned PadW    = EntryW - FrameW - PteShift;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [NfW-1:0]   MaxNf    = NfW'(MAX_TABLES);

  // sequencer states
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StEval  = 3'd3;
  localparam logic [2:0] StAlloc = 3'd4;
  localparam logic [2:0] StRd1   = 3'd5;
  localparam logic [2:0] StLeaf  = 3'd6;
  localparam logic [2:0] StFin   = 3'd7;

  logic [2:0]             state_q, state_d;
  logic [FrameW-1:0]      base_q;
  logic [NfW-1:0]         next_free_q, next_free_d;
  logic [AddrW-1:0]       clr_q, clr_d;
  logic [VpnW-1:0]        vpn_q, vpn_d;
  logic [FrameW-1:0]      ppn_q, ppn_d;
  logic [CountW-1:0]      count_q, count_d;
  logic [PermW-1:0]       perm_q, perm_d;
  logic [CountW-1:0]      done_q, done_d;
  logic                   status_q, status_d;
  logic                   lvl_q, lvl_d;
  logic [TblW-1:0]        child_q, child_d;
  logic [AddrW-1:0]       where_q, where_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_status_q, out_status_d;
  logic [CountW-1:0]      out_pages_q, out_pages_d;
  logic [TablesUsedW-1:0] out_tables_q, out_tables_d;

  logic                   ram_we;
  logic [AddrW-1:0]       ram_addr;
  logic [EntryW-1:0]      ram_wdata, ram_rdata;
  logic [FrameW-1:0]      alu_a, alu_b, alu_sum;
  logic                   alu_sub;

  logic [IdxW-1:0]        idx2, idx1, idx0;
  logic                   hit;
  logic                   in_fire;

  assign idx2 = vpn_q[3*IdxW-1:2*IdxW];
  assign idx1 = vpn_q[2*IdxW-1:IdxW];
  assign idx0 = vpn_q[IdxW-1:0];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;

  sptb_ram #(
    .Width (EntryW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  sptb_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum)
  );

  // Shared adder: pointer offset check, new table frame, physical page step.
  always_comb begin
    alu_a   = ppn_q;
    alu_b   = FrameW'(1);
    alu_sub = 1'b0;
    case (state_q)
      StEval: begin
        alu_a   = ram_rdata[PteShift +: FrameW];
        alu_b   = base_q;
        alu_sub = 1'b1;
      end
      StAlloc: begin
        alu_a = base_q;
        alu_b = FrameW'(next_free_q);
      end
      default: ;
    endcase
  end

  // A stored pointer counts only if it names a table already handed out.
  assign hit = ram_rdata[0] && (alu_sum < FrameW'(next_free_q));

  always_comb begin
    state_d      = state_q;
    next_free_d  = next_free_q;
    clr_d        = clr_q;
    vpn_d        = vpn_q;
    ppn_d        = ppn_q;
    count_d      = count_q;
    perm_d       = perm_q;
    done_d       = done_q;
    status_d     = status_q;
    lvl_d        = lvl_q;
    child_d      = child_q;
    where_d      = where_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_pages_d  = out_pages_q;
    out_tables_d = out_tables_q;
    ram_we       = 1'b0;
    ram_addr     = where_q;
    ram_wdata    = '0;

    case (state_q)
      StClear: begin
        // sweep the store to zero, one entry a cycle
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + AddrW'(1);
        if (clr_q == LastAddr) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_fire) begin
          vpn_d    = virt_page_i;
          ppn_d    = phys_page_i;
          count_d  = page_count_i;
          perm_d   = permission_i;
          done_d   = '0;
          status_d = 1'b0;
          state_d  = StCheck;
        end
      end
      StCheck: begin
        if (done_q == count_q) begin
          state_d = StFin;
        end else begin
          // read the root entry
          ram_addr = {TblW'(0), idx2};
          where_d  = {TblW'(0), idx2};
          lvl_d    = 1'b0;
          state_d  = StEval;
        end
      end
      StEval: begin
        if (hit) begin
          if (!lvl_q) begin
            ram_addr = {alu_sum[TblW-1:0], idx1};
            where_d  = {alu_sum[TblW-1:0], idx1};
            lvl_d    = 1'b1;
          end else begin
            child_d = alu_sum[TblW-1:0];
            state_d = StLeaf;
          end
        end else if (next_free_q >= MaxNf) begin
          // pool exhausted: drop the rest of the request
          status_d = 1'b1;
          state_d  = StFin;
        end else begin
          state_d = StAlloc;
        end
      end
      StAlloc: begin
        ram_we      = 1'b1;
        ram_wdata   = {PadW'(0), alu_sum, (PteShift - 1)'(0), 1'b1};
        child_d     = next_free_q[TblW-1:0];
        next_free_d = next_free_q + NfW'(1);
        state_d     = lvl_q ? StLeaf : StRd1;
      end
      StRd1: begin
        ram_addr = {child_q, idx1};
        where_d  = {child_q, idx1};
        lvl_d    = 1'b1;
        state_d  = StEval;
      end
      StLeaf: begin
        ram_we    = 1'b1;
        ram_addr  = {child_q, idx0};
        ram_wdata = {PadW'(0), ppn_q, (PteShift - PermW)'(0), perm_q};
        ppn_d     = alu_sum;
        vpn_d     = vpn_q + VpnW'(1);
        done_d    = done_q + CountW'(1);
        state_d   = StCheck;
      end
      StFin: begin
        // hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_pages_d  = done_q;
          out_tables_d = TablesUsedW'(next_free_q);
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      base_q      <= '0;
      next_free_q <= NfW'(1);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_free_q <= next_free_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        base_q <= cfg_table_base_frame_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vpn_q        <= vpn_d;
    ppn_q        <= ppn_d;
    count_q      <= count_d;
    perm_q       <= perm_d;
    done_q       <= done_d;
    status_q     <= status_d;
    lvl_q        <= lvl_d;
    child_q      <= child_d;
    where_q      <= where_d;
    out_status_q <= out_status_d;
    out_pages_q  <= out_pages_d;
    out_tables_q <= out_tables_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign pages_mapped_o = out_pages_q;
  assign tables_used_o  = out_tables_q;

endmodule
